@@ rtl/pcp_pkg.sv @@
`timescale 1ns / 1ps
package pcp_pkg;

  localparam int COORD_BITS     = 24;
  localparam int MAX_POINTS_DEF = 32;

  // register and field widths
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 5;
  localparam int SEG_W   = 5;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W  = FRAC_BITS + 1;
  localparam int DIST_W  = 50;

  // datapath widths
  localparam int DW      = COORD_BITS + 1;          // coordinate difference
  localparam int SQ_W    = 2 * COORD_BITS + 2;      // sum of three squares
  localparam int PROJ_W  = 2 * COORD_BITS + 3;      // signed dot product
  localparam int MOP_W   = (DW > FRAC_W + 1) ? DW : FRAC_W + 1;
  localparam int PROD_W  = 2 * MOP_W;
  localparam int ACC_W   = 2 * COORD_BITS + FRAC_W + 4;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  PC_RESET = CNT_W'(2);

  // item operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // multiply-accumulate jobs
  localparam logic [2:0] MAC_DSQ  = 3'd0;
  localparam logic [2:0] MAC_PROJ = 3'd1;
  localparam logic [2:0] MAC_LEN  = 3'd2;
  localparam logic [2:0] MAC_SUB  = 3'd3;
  localparam logic [2:0] MAC_PT   = 3'd4;

  // segment counter operations
  localparam logic [2:0] I_HOLD     = 3'd0;
  localparam logic [2:0] I_LOAD_N   = 3'd1;
  localparam logic [2:0] I_LOAD_HOME = 3'd2;
  localparam logic [2:0] I_LOAD_ONE = 3'd3;
  localparam logic [2:0] I_INC      = 3'd4;
  localparam logic [2:0] I_DEC      = 3'd5;
  localparam logic [2:0] I_LOAD_HM1 = 3'd6;

  // best-result update sources
  localparam logic [1:0] UPD_INIT = 2'd0;
  localparam logic [1:0] UPD_ZERO = 2'd1;
  localparam logic [1:0] UPD_FRAC = 2'd2;

  typedef struct packed {
    logic                         operation;
    logic [IDX_W-1:0]             point_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [CNT_W-1:0]             start_segment;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]            distance_sq;
    logic [SEG_W-1:0]             segment;
    logic [FRAC_W-1:0]            fraction;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
  } out_item_t;

  typedef struct packed {
    logic       wr_en;
    logic       capture;
    logic [2:0] i_op;
    logic       rd_en;
    logic       rd_cur;
    logic       ld_s;
    logic       ld_l;
    logic       mac_en;
    logic [2:0] mac_op;
    logic [1:0] mac_k;
    logic       store_en;
    logic       div_start;
    logic       upd_en;
    logic [1:0] upd_src;
    logic       out_load;
  } pcp_cmd_t;

  typedef struct packed {
    logic full;
    logic proj_pos;
    logic proj_lt_len;
    logic proj_gt_len;
    logic dsq_lt_best;
    logic d_lt_best;
    logic prev_is_best;
    logic i_last;
    logic i_one;
    logic home_gt1;
    logic div_busy;
    logic out_free;
  } pcp_stat_t;

endpackage

@@ rtl/pcp_div.sv @@
`timescale 1ns / 1ps
module pcp_div import pcp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   num,
  input  logic [SQ_W-1:0]   den,
  output logic              busy,
  output logic [FRAC_W-1:0] q
);

  logic [SQ_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SQ_W:0]        rem2;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (num >= den) begin
        q    <= FRAC_ONE;
        busy <= 1'b0;
      end else begin
        rem  <= num;
        q    <= '0;
        cnt  <= DIV_CNT_W'(FRAC_BITS);
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem <= ge ? SQ_W'(rem2 - {1'b0, den}) : rem2[SQ_W-1:0];
      q   <= {q[FRAC_W-2:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/pcp_dpath.sv @@
`timescale 1ns / 1ps
module pcp_dpath import pcp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         in_item,
  input  logic             cfg_wen,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  pcp_cmd_t         cmd,
  output pcp_stat_t        stat,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  localparam int CB = COORD_BITS;
  localparam int IW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = (IW > CNT_W) ? IW : CNT_W;

  logic [3*CB-1:0] mem [MAX_POINTS];
  logic [3*CB-1:0] rdata;
  logic [AW-1:0]   raddr;

  logic [CNT_W-1:0] point_count;
  logic signed [CB-1:0] t [3];
  logic signed [CB-1:0] s [3];
  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] l [3];
  logic signed [CB-1:0] cand [3];
  logic signed [CB-1:0] bp [3];
  logic [IW-1:0] n, home, i, bseg;
  logic          full;

  logic signed [ACC_W-1:0]  acc;
  logic [SQ_W-1:0]          dsq, len, dcand, bdist;
  logic signed [PROJ_W-1:0] proj;
  logic [SQ_W-1:0]          proj_mag;
  logic [FRAC_W-1:0]        f, bfrac;
  logic                     div_busy;

  logic [IW-1:0] n_calc, home_calc;
  logic          full_calc;
  logic signed [CB-1:0] rd_x, rd_y, rd_z;

  logic signed [DW-1:0]    d_k, l_k;
  logic signed [CB-1:0]    s_k;
  logic [CB-1:0]           chunk_k;
  logic [3*CB-1:0]         proj_ext;
  logic signed [MOP_W-1:0] ma, mb;
  logic signed [PROD_W-1:0] prod, pt_sh;
  logic signed [ACC_W-1:0] prod_ext, addend, acc_base;
  logic [ACC_W-1:0]        acc_sh;

  // query setup from the point count register
  always_comb begin
    if (point_count < CNT_W'(2)) begin
      n_calc = IW'(2);
    end else if (CW'(point_count) > CW'(MAX_POINTS)) begin
      n_calc = IW'(MAX_POINTS);
    end else begin
      n_calc = IW'(point_count);
    end
  end

  assign full_calc = (in_item.start_segment >= point_count) ||
                     (CW'(in_item.start_segment) >= CW'(n_calc));
  assign home_calc = (in_item.start_segment == '0) ? IW'(1) : IW'(in_item.start_segment);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
    end else if (cfg_wen) begin
      point_count <= cfg_wdata;
    end
  end

  // point store
  assign raddr = cmd.rd_cur ? AW'(i) : AW'(i - IW'(1));

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (int'(in_item.point_index) < MAX_POINTS)) begin
      mem[AW'(in_item.point_index)] <= {in_item.coord_x, in_item.coord_y, in_item.coord_z};
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  assign rd_x = rdata[3*CB-1:2*CB];
  assign rd_y = rdata[2*CB-1:CB];
  assign rd_z = rdata[CB-1:0];

  // operand selection for the shared multiplier
  always_comb begin
    case (cmd.mac_k)
      2'd0: begin d_k = d[0]; l_k = l[0]; s_k = s[0]; end
      2'd1: begin d_k = d[1]; l_k = l[1]; s_k = s[1]; end
      default: begin d_k = d[2]; l_k = l[2]; s_k = s[2]; end
    endcase
  end

  assign proj_mag = proj[SQ_W-1:0];
  assign proj_ext = (3*CB)'(proj_mag);

  always_comb begin
    case (cmd.mac_k)
      2'd0: chunk_k = proj_ext[CB-1:0];
      2'd1: chunk_k = proj_ext[2*CB-1:CB];
      default: chunk_k = proj_ext[3*CB-1:2*CB];
    endcase
  end

  always_comb begin
    case (cmd.mac_op)
      MAC_PROJ: begin ma = MOP_W'(d_k); mb = MOP_W'(l_k); end
      MAC_LEN:  begin ma = MOP_W'(l_k); mb = MOP_W'(l_k); end
      MAC_SUB:  begin
        ma = MOP_W'($signed({1'b0, f}));
        mb = MOP_W'($signed({1'b0, chunk_k}));
      end
      MAC_PT:   begin ma = MOP_W'($signed({1'b0, f})); mb = MOP_W'(l_k); end
      default:  begin ma = MOP_W'(d_k); mb = MOP_W'(d_k); end
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = ACC_W'(prod);
  assign pt_sh    = prod >>> FRAC_BITS;
  assign acc_base = (cmd.mac_k == 2'd0) ? '0 : acc;

  // proj chunks weigh in at their bit position
  always_comb begin
    if (cmd.mac_op == MAC_SUB) begin
      case (cmd.mac_k)
        2'd0: addend = prod_ext;
        2'd1: addend = prod_ext <<< CB;
        default: addend = prod_ext <<< (2 * CB);
      endcase
    end else begin
      addend = prod_ext;
    end
  end

  assign acc_sh = acc >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t[0] <= in_item.coord_x;
      t[1] <= in_item.coord_y;
      t[2] <= in_item.coord_z;
      n    <= n_calc;
      home <= home_calc;
      full <= full_calc;
    end

    case (cmd.i_op)
      I_LOAD_N:    i <= n;
      I_LOAD_HOME: i <= home;
      I_LOAD_ONE:  i <= IW'(1);
      I_INC:       i <= i + IW'(1);
      I_DEC:       i <= i - IW'(1);
      I_LOAD_HM1:  i <= home - IW'(1);
      default:     i <= i;
    endcase

    if (cmd.ld_s) begin
      s[0] <= rd_x;
      s[1] <= rd_y;
      s[2] <= rd_z;
      d[0] <= DW'(t[0]) - DW'(rd_x);
      d[1] <= DW'(t[1]) - DW'(rd_y);
      d[2] <= DW'(t[2]) - DW'(rd_z);
    end
    if (cmd.ld_l) begin
      l[0] <= DW'(rd_x) - DW'(s[0]);
      l[1] <= DW'(rd_y) - DW'(s[1]);
      l[2] <= DW'(rd_z) - DW'(s[2]);
    end

    if (cmd.mac_en) begin
      if (cmd.mac_op == MAC_PT) begin
        case (cmd.mac_k)
          2'd0: cand[0] <= s_k + pt_sh[CB-1:0];
          2'd1: cand[1] <= s_k + pt_sh[CB-1:0];
          default: cand[2] <= s_k + pt_sh[CB-1:0];
        endcase
      end else begin
        acc <= acc_base + addend;
      end
    end

    if (cmd.store_en) begin
      case (cmd.mac_op)
        MAC_DSQ:  dsq  <= acc[SQ_W-1:0];
        MAC_PROJ: proj <= acc[PROJ_W-1:0];
        MAC_LEN:  len  <= acc[SQ_W-1:0];
        default:  dcand <= (acc_sh >= ACC_W'(dsq)) ? '0 : dsq - acc_sh[SQ_W-1:0];
      endcase
    end

    if (cmd.upd_en) begin
      case (cmd.upd_src)
        UPD_INIT: begin
          bdist <= dsq;
          bseg  <= i - IW'(1);
          bfrac <= FRAC_ONE;
          bp[0] <= s[0]; bp[1] <= s[1]; bp[2] <= s[2];
        end
        UPD_ZERO: begin
          bdist <= dsq;
          bseg  <= i;
          bfrac <= '0;
          bp[0] <= s[0]; bp[1] <= s[1]; bp[2] <= s[2];
        end
        default: begin
          bdist <= dcand;
          bseg  <= i;
          bfrac <= f;
          bp[0] <= cand[0]; bp[1] <= cand[1]; bp[2] <= cand[2];
        end
      endcase
    end

    if (cmd.out_load) begin
      out_item.distance_sq <= DIST_W'(bdist);
      out_item.segment     <= SEG_W'(bseg);
      out_item.fraction    <= bfrac;
      out_item.near_x      <= bp[0];
      out_item.near_y      <= bp[1];
      out_item.near_z      <= bp[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  pcp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (proj_mag),
    .den   (len),
    .busy  (div_busy),
    .q     (f)
  );

  always_comb begin
    stat.full         = full;
    stat.proj_pos     = !proj[PROJ_W-1] && (proj != '0);
    stat.proj_lt_len  = proj_mag < len;
    stat.proj_gt_len  = proj_mag > len;
    stat.dsq_lt_best  = dsq < bdist;
    stat.d_lt_best    = dcand < bdist;
    stat.prev_is_best = bseg == (i - IW'(1));
    stat.i_last       = i == (n - IW'(1));
    stat.i_one        = i == IW'(1);
    stat.home_gt1     = home > IW'(1);
    stat.div_busy     = div_busy;
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

@@ rtl/pcp_ctrl.sv @@
`timescale 1ns / 1ps
module pcp_ctrl import pcp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  input  pcp_stat_t stat,
  output pcp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_RD_S   = 4'd2;
  localparam logic [3:0] S_RD_E   = 4'd3;
  localparam logic [3:0] S_LD_E   = 4'd4;
  localparam logic [3:0] S_MAC    = 4'd5;
  localparam logic [3:0] S_STORE  = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_LCHK   = 4'd8;
  localparam logic [3:0] S_DIVGO  = 4'd9;
  localparam logic [3:0] S_DIVW   = 4'd10;
  localparam logic [3:0] S_DCHK   = 4'd11;
  localparam logic [3:0] S_UPD    = 4'd12;
  localparam logic [3:0] S_NEXT   = 4'd13;
  localparam logic [3:0] S_BSTART = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  localparam logic [2:0] PH_INIT = 3'd0;
  localparam logic [2:0] PH_FULL = 3'd1;
  localparam logic [2:0] PH_HOME = 3'd2;
  localparam logic [2:0] PH_FWD  = 3'd3;
  localparam logic [2:0] PH_BWD  = 3'd4;

  logic [3:0] state, state_next;
  logic [2:0] phase, phase_next;
  logic [2:0] op, op_next;
  logic [1:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_INIT;
      op    <= MAC_DSQ;
      k     <= 2'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      op    <= op_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    op_next    = op;
    k_next     = k;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.i_op   = I_HOLD;
    cmd.mac_op = op;
    cmd.mac_k  = k;
    cmd.upd_src = UPD_ZERO;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.capture = 1'b1;
            state_next  = S_SETUP;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_SETUP: begin
        if (stat.full) begin
          cmd.i_op   = I_LOAD_N;
          phase_next = PH_INIT;
        end else begin
          cmd.i_op   = I_LOAD_HOME;
          phase_next = PH_HOME;
        end
        state_next = S_RD_S;
      end
      S_RD_S: begin
        cmd.rd_en  = 1'b1;
        state_next = S_RD_E;
      end
      S_RD_E: begin
        cmd.ld_s   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_cur = 1'b1;
        if (phase == PH_INIT) begin
          op_next    = MAC_DSQ;
          k_next     = 2'd0;
          state_next = S_MAC;
        end else begin
          state_next = S_LD_E;
        end
      end
      S_LD_E: begin
        cmd.ld_l   = 1'b1;
        op_next    = MAC_DSQ;
        k_next     = 2'd0;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        if (k == 2'd2) begin
          k_next     = 2'd0;
          state_next = (op == MAC_PT) ? S_UPD : S_STORE;
        end else begin
          k_next = k + 2'd1;
        end
      end
      S_STORE: begin
        cmd.store_en = 1'b1;
        case (op)
          MAC_DSQ: begin
            if (phase == PH_INIT) begin
              state_next = S_UPD;
            end else begin
              op_next    = MAC_PROJ;
              state_next = S_MAC;
            end
          end
          MAC_PROJ: state_next = S_DECIDE;
          MAC_LEN:  state_next = S_LCHK;
          default:  state_next = S_DCHK;
        endcase
      end
      S_DECIDE: begin
        op_next = MAC_LEN;
        if (stat.proj_pos) begin
          state_next = S_MAC;
        end else begin
          case (phase)
            PH_FULL: begin
              if (!stat.prev_is_best && stat.dsq_lt_best) begin
                cmd.upd_en = 1'b1;
              end
              state_next = S_NEXT;
            end
            PH_HOME: begin
              cmd.upd_en = 1'b1;
              state_next = S_NEXT;
            end
            PH_FWD: state_next = S_BSTART;
            default: begin
              if (stat.dsq_lt_best) begin
                cmd.upd_en = 1'b1;
                state_next = S_NEXT;
              end else begin
                state_next = S_FIN;
              end
            end
          endcase
        end
      end
      S_LCHK: begin
        case (phase)
          PH_FULL: state_next = stat.proj_lt_len ? S_DIVGO : S_NEXT;
          PH_BWD:  state_next = stat.proj_gt_len ? S_FIN : S_DIVGO;
          default: state_next = S_DIVGO;
        endcase
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (!stat.div_busy) begin
          op_next    = MAC_SUB;
          k_next     = 2'd0;
          state_next = S_MAC;
        end
      end
      S_DCHK: begin
        op_next = MAC_PT;
        k_next  = 2'd0;
        case (phase)
          PH_FULL: state_next = stat.d_lt_best ? S_MAC : S_NEXT;
          PH_HOME: state_next = S_MAC;
          PH_FWD:  state_next = stat.d_lt_best ? S_MAC : S_BSTART;
          default: state_next = stat.d_lt_best ? S_MAC : S_FIN;
        endcase
      end
      S_UPD: begin
        cmd.upd_en = 1'b1;
        if (phase == PH_INIT) begin
          cmd.upd_src = UPD_INIT;
          cmd.i_op    = I_LOAD_ONE;
          phase_next  = PH_FULL;
          state_next  = S_RD_S;
        end else begin
          cmd.upd_src = UPD_FRAC;
          state_next  = S_NEXT;
        end
      end
      S_NEXT: begin
        case (phase)
          PH_FULL: begin
            if (stat.i_last) begin
              state_next = S_FIN;
            end else begin
              cmd.i_op   = I_INC;
              state_next = S_RD_S;
            end
          end
          PH_BWD: begin
            if (stat.i_one) begin
              state_next = S_FIN;
            end else begin
              cmd.i_op   = I_DEC;
              state_next = S_RD_S;
            end
          end
          default: begin
            if (stat.i_last) begin
              state_next = S_BSTART;
            end else begin
              cmd.i_op   = I_INC;
              phase_next = PH_FWD;
              state_next = S_RD_S;
            end
          end
        endcase
      end
      S_BSTART: begin
        if (stat.home_gt1) begin
          cmd.i_op   = I_LOAD_HM1;
          phase_next = PH_BWD;
          state_next = S_RD_S;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/polyline_closest_point.sv @@
`timescale 1ns / 1ps
// closest point on a stored polyline of up to MAX_POINTS 3d points
// input channel (in_valid/in_ready/in_item): a write transaction stores one
//   point at point_index and gives no result; a query transaction
//   carries a test point and a start segment and gives exactly one result
// output channel (out_valid/out_ready/out_item): squared distance, segment,
//   fraction and nearest point, held in an output register until taken
// configuration: cfg_wen/cfg_wdata write point_count at once; the user must
//   write it only while idle, which the block itself does not enforce
// search: a query visits segments one after another through one shared
//   multiplier and a 16-step divider; a full search first scores the end
//   point and then visits all n-1 segments, n being point_count clamped to
//   the range 2 to MAX_POINTS
// throughput: one query at a time; the next item is taken as soon as the
//   result sits in the output register, even while the receiver stalls
// a stalled receiver holds the result, and a finished query waits for room
// reset clears control state and sets point_count to 2; the point store
//   holds nothing until written
module polyline_closest_point import pcp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_wen,
  input  logic [CNT_W-1:0] cfg_wdata
);

  // command and status between the sequencer and the datapath
  pcp_cmd_t  cmd;
  pcp_stat_t stat;

  // sequencer: walks segments and the forward and backward searches
  pcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_item.operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: point store, multiply-accumulate, divider, best result
  pcp_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import pcp_pkg::*;

  // geometry of a segment as seen from the test point
  typedef struct {
    longint dx, dy, dz;   // test point minus segment start
    longint lx, ly, lz;   // segment end minus segment start
    longint proj;         // dot product of the two, an integer
    longint dsq;          // squared length of the first, an integer
  } seg_geom_t;

  // one row of the directed table
  typedef struct {
    in_item_t  item;
    bit        typed;     // result typed in by hand rather than predicted
    out_item_t res;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_wen = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  polyline_closest_point u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block's point store and point_count register
  longint           pts_x[MAX_POINTS_DEF];
  longint           pts_y[MAX_POINTS_DEF];
  longint           pts_z[MAX_POINTS_DEF];
  logic [CNT_W-1:0] count_reg = PC_RESET;

  out_item_t pending_results[$];
  int        mismatches = 0;
  int        n_writes = 0;
  int        n_queries = 0;
  int        n_results = 0;
  int        n_settings = 0;

  // idling controls, percent of cycles
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;      // long receiver hold-off, in cycles

  // ---------------------------------------------------------------------
  // closest point predictor
  // ---------------------------------------------------------------------
  function automatic longint floor_q16(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v + 65535) >>> 16);
  endfunction

  function automatic seg_geom_t seg_geom(longint tx, longint ty, longint tz, int i);
    seg_geom_t g;
    int s;
    s = i - 1;
    g.dx = tx - pts_x[s];
    g.dy = ty - pts_y[s];
    g.dz = tz - pts_z[s];
    g.lx = pts_x[i] - pts_x[s];
    g.ly = pts_y[i] - pts_y[s];
    g.lz = pts_z[i] - pts_z[s];
    g.proj = g.dx * g.lx + g.dy * g.ly + g.dz * g.lz;
    g.dsq = g.dx * g.dx + g.dy * g.dy + g.dz * g.dz;
    return g;
  endfunction

  function automatic longint seg_len_sq(seg_geom_t g);
    return g.lx * g.lx + g.ly * g.ly + g.lz * g.lz;
  endfunction

  // restoring 16-step division, saturating at one
  function automatic longint frac_along(longint proj, longint len);
    longint r, q;
    r = proj;
    q = 0;
    if (proj >= len) return 65536;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= len) begin
        r = r - len;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint dist_left(longint dsq, longint f, longint proj);
    longint sub;
    sub = f * (proj >>> 16) + ((f * (proj & 64'hFFFF)) >>> 16);
    return (sub >= dsq) ? 0 : dsq - sub;
  endfunction

  function automatic out_item_t closest_point(in_item_t it);
    longint    tx, ty, tz, bd, bf, bpx, bpy, bpz, f, d, len;
    int        n, st, home, bs, last;
    seg_geom_t g;
    out_item_t r;
    tx = it.coord_x;
    ty = it.coord_y;
    tz = it.coord_z;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    st = it.start_segment;
    if (st >= count_reg || st >= n) begin
      // full search, seeded with the polyline end
      last = n - 1;
      bs = last;
      bf = 65536;
      bpx = pts_x[last];
      bpy = pts_y[last];
      bpz = pts_z[last];
      bd = (tx - bpx) * (tx - bpx) + (ty - bpy) * (ty - bpy) + (tz - bpz) * (tz - bpz);
      for (int i = 1; i < n; i++) begin
        g = seg_geom(tx, ty, tz, i);
        if (g.proj <= 0) begin
          // segment start, skipped when the previous segment holds the best
          if (bs != i - 1 && g.dsq < bd) begin
            bd = g.dsq; bs = i; bf = 0;
            bpx = pts_x[i-1]; bpy = pts_y[i-1]; bpz = pts_z[i-1];
          end
        end else begin
          len = seg_len_sq(g);
          if (g.proj < len) begin
            f = frac_along(g.proj, len);
            d = dist_left(g.dsq, f, g.proj);
            if (d < bd) begin
              bd = d; bs = i; bf = f;
              bpx = pts_x[i-1] + floor_q16(f * g.lx);
              bpy = pts_y[i-1] + floor_q16(f * g.ly);
              bpz = pts_z[i-1] + floor_q16(f * g.lz);
            end
          end
        end
      end
    end else begin
      // local search; start segment zero acts as one
      home = (st == 0) ? 1 : st;
      g = seg_geom(tx, ty, tz, home);
      bs = home;
      if (g.proj <= 0) begin
        bd = g.dsq;
        bf = 0;
      end else begin
        bf = frac_along(g.proj, seg_len_sq(g));
        bd = dist_left(g.dsq, bf, g.proj);
      end
      bpx = pts_x[home-1] + floor_q16(bf * g.lx);
      bpy = pts_y[home-1] + floor_q16(bf * g.ly);
      bpz = pts_z[home-1] + floor_q16(bf * g.lz);
      // forward walk, stops on the first non-improving segment
      for (int i = home + 1; i < n; i++) begin
        g = seg_geom(tx, ty, tz, i);
        if (g.proj <= 0) break;
        f = frac_along(g.proj, seg_len_sq(g));
        d = dist_left(g.dsq, f, g.proj);
        if (d >= bd) break;
        bd = d; bs = i; bf = f;
        bpx = pts_x[i-1] + floor_q16(f * g.lx);
        bpy = pts_y[i-1] + floor_q16(f * g.ly);
        bpz = pts_z[i-1] + floor_q16(f * g.lz);
      end
      // backward walk, reports the segment it improves on
      for (int i = home - 1; i > 0; i--) begin
        g = seg_geom(tx, ty, tz, i);
        if (g.proj <= 0) begin
          if (g.dsq >= bd) break;
          bd = g.dsq; bs = i; bf = 0;
          bpx = pts_x[i-1]; bpy = pts_y[i-1]; bpz = pts_z[i-1];
        end else begin
          len = seg_len_sq(g);
          if (g.proj > len) break;
          f = frac_along(g.proj, len);
          d = dist_left(g.dsq, f, g.proj);
          if (d >= bd) break;
          bd = d; bs = i; bf = f;
          bpx = pts_x[i-1] + floor_q16(f * g.lx);
          bpy = pts_y[i-1] + floor_q16(f * g.ly);
          bpz = pts_z[i-1] + floor_q16(f * g.lz);
        end
      end
    end
    r.distance_sq = bd[DIST_W-1:0];
    r.segment     = bs[SEG_W-1:0];
    r.fraction    = bf[FRAC_W-1:0];
    r.near_x      = bpx[COORD_BITS-1:0];
    r.near_y      = bpy[COORD_BITS-1:0];
    r.near_z      = bpz[COORD_BITS-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------
  // offers one transaction from a falling edge, returns on the falling edge
  // after it was taken; tracks the shadow store and the expected results
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (it.operation == OP_WRITE) begin
      pts_x[it.point_index] = it.coord_x;
      pts_y[it.point_index] = it.coord_y;
      pts_z[it.point_index] = it.coord_z;
      n_writes++;
    end else begin
      pending_results.push_back(typed ? res : closest_point(it));
      n_queries++;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_item_t make_item(logic op, int idx, int x, int y, int z, int st);
    in_item_t it;
    it.operation     = op;
    it.point_index   = idx[IDX_W-1:0];
    it.coord_x       = x[COORD_BITS-1:0];
    it.coord_y       = y[COORD_BITS-1:0];
    it.coord_z       = z[COORD_BITS-1:0];
    it.start_segment = st[CNT_W-1:0];
    return it;
  endfunction

  function automatic out_item_t make_res(longint d, int s, int f, int x, int y, int z);
    out_item_t r;
    r.distance_sq = d[DIST_W-1:0];
    r.segment     = s[SEG_W-1:0];
    r.fraction    = f[FRAC_W-1:0];
    r.near_x      = x[COORD_BITS-1:0];
    r.near_y      = y[COORD_BITS-1:0];
    r.near_z      = z[COORD_BITS-1:0];
    return r;
  endfunction

  // coordinates: mostly small so searches travel, sometimes the full range
  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return $signed($urandom_range(24'hFFFFFF, 0) << 8) >>> 8;
    if (sel < 20) return ($urandom_range(1)) ? 8388607 : -8388608;
    return int'($urandom_range(4096)) - 2048;
  endfunction

  function automatic in_item_t rand_item(int n);
    int idx, x, y, z, st;
    if ($urandom_range(1)) begin
      // write: nearly half the time a gently winding curve so local searches walk far
      idx = ($urandom_range(3) != 0) ? $urandom_range(n - 1) : $urandom_range(31);
      if ($urandom_range(99) < 45) begin
        x = idx * 256 + int'($urandom_range(128)) - 64;
        y = (idx % 5) * 96 + int'($urandom_range(64)) - 32;
        z = int'($urandom_range(64)) - 32;
      end else begin
        x = rand_coord(); y = rand_coord(); z = rand_coord();
      end
      return make_item(OP_WRITE, idx, x, y, z, $urandom_range(63));
    end
    st = ($urandom_range(99) < 65) ? $urandom_range(n - 1) : $urandom_range(63);
    if ($urandom_range(99) < 50) begin
      x = int'($urandom_range(n * 256)) - 128;
      y = int'($urandom_range(768)) - 256;
      z = int'($urandom_range(256)) - 128;
    end else begin
      x = rand_coord(); y = rand_coord(); z = rand_coord();
    end
    return make_item(OP_QUERY, $urandom_range(31), x, y, z, st);
  endfunction

  // point_count changes only once the block has drained
  task automatic write_count(input logic [CNT_W-1:0] value);
    while (pending_results.size() != 0) @(negedge clk);
    // a write transaction gives no result, so let any search settle
    repeat (1400) @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen = 1'b0;
    count_reg = value;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    mismatches++;
  endtask

  // each accepted result against the oldest expectation, field by field
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.distance_sq !== want.distance_sq)
          report_mismatch("distance_sq", out_item.distance_sq, want.distance_sq);
        if (out_item.segment !== want.segment)
          report_mismatch("segment", out_item.segment, want.segment);
        if (out_item.fraction !== want.fraction)
          report_mismatch("fraction", out_item.fraction, want.fraction);
        if (out_item.near_x !== want.near_x)
          report_mismatch("near_x", out_item.near_x, want.near_x);
        if (out_item.near_y !== want.near_y)
          report_mismatch("near_y", out_item.near_y, want.near_y);
        if (out_item.near_z !== want.near_z)
          report_mismatch("near_z", out_item.near_z, want.near_z);
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    dir_row_t   rows[$];
    dir_row_t   row;
    in_item_t   it;
    int         counts[8] = '{3, 2, 32, 0, 63, 7, 17, 4};
    int         phase_items, n;
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      pts_x[i] = 0; pts_y[i] = 0; pts_z[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table, point_count at its reset value of two
    row.typed = 0; row.res = '0;
    row.item = make_item(OP_WRITE, 0, 0, 0, 0, 0);              rows.push_back(row);
    row.item = make_item(OP_WRITE, 1, 256, 0, 0, 0);            rows.push_back(row);
    // test point on the segment start: zero distance
    row.typed = 1;
    row.item = make_item(OP_QUERY, 0, 0, 0, 0, 1);
    row.res  = make_res(0, 1, 0, 0, 0, 0);                      rows.push_back(row);
    // full search beyond the end: the end point wins
    row.item = make_item(OP_QUERY, 31, 512, 0, 0, 63);
    row.res  = make_res(65536, 1, 65536, 256, 0, 0);            rows.push_back(row);
    // start segment zero acts as one, halfway along
    row.item = make_item(OP_QUERY, 0, 128, 256, 0, 0);
    row.res  = make_res(65536, 1, 32768, 128, 0, 0);            rows.push_back(row);
    row.typed = 0; row.res = '0;
    row.item = make_item(OP_QUERY, 0, -300, 40, -7, 2);         rows.push_back(row);
    // extremes of the coordinate range
    row.item = make_item(OP_WRITE, 0, -8388608, -8388608, -8388608, 63); rows.push_back(row);
    row.item = make_item(OP_WRITE, 1, 8388607, 8388607, 8388607, 0);     rows.push_back(row);
    row.item = make_item(OP_QUERY, 31, 0, 0, 0, 1);             rows.push_back(row);
    row.item = make_item(OP_QUERY, 0, 8388607, -8388608, 8388607, 63); rows.push_back(row);
    row.item = make_item(OP_QUERY, 0, -8388608, -8388608, -8388608, 0); rows.push_back(row);
    row.item = make_item(OP_QUERY, 0, 8388607, 8388607, 8388607, 1); rows.push_back(row);
    // zero length segment
    row.item = make_item(OP_WRITE, 1, -8388608, -8388608, -8388608, 0); rows.push_back(row);
    row.item = make_item(OP_QUERY, 0, 1000, -1000, 5, 1);       rows.push_back(row);
    row.item = make_item(OP_QUERY, 0, 1000, -1000, 5, 40);      rows.push_back(row);
    row.item = make_item(OP_WRITE, 0, 100, 100, 100, 0);        rows.push_back(row);
    row.item = make_item(OP_WRITE, 1, 100, 100, 100, 0);        rows.push_back(row);
    row.item = make_item(OP_QUERY, 0, 99, 101, -3, 1);          rows.push_back(row);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);

    // fill the whole store so no query reads an unwritten entry
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      it = make_item(OP_WRITE, i, i * 256, (i % 5) * 96, 0, 0);
      send_item(it, 0, '0);
    end

    foreach (counts[p]) begin
      write_count(counts[p][CNT_W-1:0]);
      n = (counts[p] < 2) ? 2 : ((counts[p] > MAX_POINTS_DEF) ? MAX_POINTS_DEF : counts[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // long hold-off so results back up and the input stalls
      if (p == 1 || p == 5) hold_left = 3000;
      phase_items = (n > 20) ? 45 : 110;
      for (int k = 0; k < phase_items; k++) begin
        send_item(rand_item(n), 0, '0);
        // a stretch with no idling inside each phase
        if (k == phase_items / 2) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      end
    end

    while (pending_results.size() != 0) @(negedge clk);
    repeat (1400) @(negedge clk);
    $display("covered %0d point writes and %0d queries, %0d results checked",
             n_writes, n_queries, n_results);
    $display("over %0d point_count settings, under idle, stall and hold-off phases",
             n_settings);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #80_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pcp_pkg.sv
rtl/pcp_div.sv
rtl/pcp_dpath.sv
rtl/pcp_ctrl.sv
rtl/polyline_closest_point.sv
tb/testbench.sv
